// File: rtl/artdmx_pkg.sv
// Shared types, constants and a helper function for the ArtDmx packet router.
// No dependencies; every other file of the router imports this package.
`timescale 1ns / 1ps

package artdmx_pkg;

    localparam int MAX_SLOTS        = 512;
    localparam int PACKET_BYTES_DEF = 530;

    localparam int IDENT_BYTES      = 8;
    localparam int POS_OPCODE_LO    = 8;
    localparam int POS_OPCODE_HI    = 9;
    localparam int MIN_PACKET_BYTES = 10;
    localparam int POS_UNIVERSE     = 14;
    localparam int POS_NET          = 15;
    localparam int POS_LENGTH_HI    = 16;
    localparam int POS_LENGTH_LO    = 17;
    localparam int DATA_START       = 18;

    localparam logic [15:0] OP_DMX        = 16'h5000;
    localparam logic [15:0] OP_POLL       = 16'h2000;
    localparam logic [15:0] OP_POLL_REPLY = 16'h2100;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 7;
    localparam int NUM_OUTPUTS = 4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NET        = 3'd0,
        REG_SUBNET     = 3'd1,
        REG_UNIVERSE_A = 3'd2,
        REG_UNIVERSE_B = 3'd3,
        REG_UNIVERSE_C = 3'd4,
        REG_UNIVERSE_D = 3'd5
    } t_reg_index;

    typedef enum logic {
        KIND_SLOT    = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        CLS_NOT_ARTNET = 3'd0,
        CLS_DMX        = 3'd1,
        CLS_POLL       = 3'd2,
        CLS_POLL_REPLY = 3'd3,
        CLS_UNKNOWN    = 3'd4,
        CLS_SHORT      = 3'd5
    } t_class;

    typedef struct packed {
        logic [6:0]                   net;
        logic [3:0]                   subnet;
        logic [NUM_OUTPUTS-1:0][3:0]  universe;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [8:0]  slot_index;
        logic [7:0]  slot_value;
        logic [3:0]  target_mask;
        t_class      packet_class;
        logic [15:0] announced_length;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0]         count;
        t_result [1:0]      entry;
    } t_push;

    function automatic logic [7:0] ident_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h41;
            3'd1:    b = 8'h72;
            3'd2:    b = 8'h74;
            3'd3:    b = 8'h2D;
            3'd4:    b = 8'h4E;
            3'd5:    b = 8'h65;
            3'd6:    b = 8'h74;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/artdmx_packet_router.sv
// Top level of the ArtDmx packet router: configuration, parser and result queue.
// Depends on artdmx_pkg, artdmx_cfg, artdmx_parser and artdmx_out_fifo.
`timescale 1ns / 1ps

// The router takes one UDP payload byte per item and can accept an item in every
// cycle in which the input does not stall. Each accepted byte is held in an input
// register and parsed from there once the result queue has room; its results are
// written into a four-entry result queue and leave the output at one per cycle
// while the output is not stalled. A byte yields at most one DMX slot result plus,
// on the end-of-packet byte, a summary; only an end byte that also carries a slot
// makes two results. The input stalls while a byte waits in the input register and
// the queue holds more than two results. Configuration registers are written
// through the plain write port and take effect for the bytes that follow.
module artdmx_packet_router #(
    parameter int PACKET_BYTES = artdmx_pkg::PACKET_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_payload_byte,
    input  logic                                i_end_of_packet,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_result_kind,
    output logic [8:0]                          o_slot_index,
    output logic [7:0]                          o_slot_value,
    output logic [3:0]                          o_target_mask,
    output logic [2:0]                          o_packet_class,
    output logic [15:0]                         o_announced_length,
    output logic                                o_last_result,
    input  logic                                i_cfg_we,
    input  logic [artdmx_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [artdmx_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import artdmx_pkg::*;

    t_cfg    cfg;
    t_push   push;
    t_result result;
    logic    room;

    artdmx_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    artdmx_parser #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_payload_byte  (i_payload_byte),
        .i_end_of_packet (i_end_of_packet),
        .o_in_stall      (o_in_stall),
        .i_cfg           (cfg),
        .i_room          (room),
        .o_push          (push)
    );

    artdmx_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_result_kind      = result.kind;
    assign o_slot_index       = result.slot_index;
    assign o_slot_value       = result.slot_value;
    assign o_target_mask      = result.target_mask;
    assign o_packet_class     = result.packet_class;
    assign o_announced_length = result.announced_length;
    assign o_last_result      = result.last;

endmodule

// File: rtl/artdmx_cfg.sv
// Configuration registers of the ArtDmx packet router (net, subnet, universes).
// Depends on artdmx_pkg for the register indexes and the t_cfg struct.
`timescale 1ns / 1ps

module artdmx_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [artdmx_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [artdmx_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output artdmx_pkg::t_cfg                    o_cfg
);
    import artdmx_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.net         <= 7'd0;
            r_cfg.subnet      <= 4'd0;
            r_cfg.universe[0] <= 4'd1;
            r_cfg.universe[1] <= 4'd2;
            r_cfg.universe[2] <= 4'd3;
            r_cfg.universe[3] <= 4'd4;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_NET:        r_cfg.net         <= i_cfg_data;
                REG_SUBNET:     r_cfg.subnet      <= i_cfg_data[3:0];
                REG_UNIVERSE_A: r_cfg.universe[0] <= i_cfg_data[3:0];
                REG_UNIVERSE_B: r_cfg.universe[1] <= i_cfg_data[3:0];
                REG_UNIVERSE_C: r_cfg.universe[2] <= i_cfg_data[3:0];
                REG_UNIVERSE_D: r_cfg.universe[3] <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/artdmx_parser.sv
// Input register and per-byte packet parser of the ArtDmx packet router.
// Depends on artdmx_pkg; produces up to two results per item for the output queue.
`timescale 1ns / 1ps

module artdmx_parser #(
    parameter int PACKET_BYTES = artdmx_pkg::PACKET_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [7:0]        i_payload_byte,
    input  logic              i_end_of_packet,
    output logic              o_in_stall,
    input  artdmx_pkg::t_cfg  i_cfg,
    input  logic              i_room,
    output artdmx_pkg::t_push o_push
);
    import artdmx_pkg::*;

    localparam int POS_W = $clog2(PACKET_BYTES + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(PACKET_BYTES);

    logic             r_in_valid;
    logic [7:0]       r_byte;
    logic             r_eop;

    logic [POS_W-1:0] r_pos;
    logic             r_hdr;
    logic [15:0]      r_op;
    logic             r_net;
    logic [3:0]       r_mask;
    logic [15:0]      r_len;

    logic [POS_W-1:0] n_pos;
    logic             n_hdr;
    logic [15:0]      n_op;
    logic             n_net;
    logic [3:0]       n_mask;
    logic [15:0]      n_len;

    logic             accept;
    logic             fire;
    logic             slot_hit;
    logic [POS_W-1:0] slot_k;
    t_class           cls;
    t_result          slot_res;
    t_result          sum_res;

    assign o_in_stall = r_in_valid && !i_room;
    assign accept     = i_in_valid && !o_in_stall;
    assign fire       = r_in_valid && i_room;
    assign slot_k     = r_pos - POS_W'(DATA_START);

    always_comb begin
        n_pos    = r_pos;
        n_hdr    = r_hdr;
        n_op     = r_op;
        n_net    = r_net;
        n_mask   = r_mask;
        n_len    = r_len;
        slot_hit = 1'b0;
        if (r_pos < POS_LIMIT) begin
            if (r_pos < POS_W'(IDENT_BYTES)) begin
                if (r_byte != ident_byte(r_pos[2:0])) begin
                    n_hdr = 1'b0;
                end
            end else if (r_pos == POS_W'(POS_OPCODE_LO)) begin
                n_op[7:0] = r_byte;
            end else if (r_pos == POS_W'(POS_OPCODE_HI)) begin
                n_op[15:8] = r_byte;
            end else if (r_pos == POS_W'(POS_UNIVERSE)) begin
                for (int i = 0; i < NUM_OUTPUTS; i++) begin
                    n_mask[i] = (r_byte == {i_cfg.subnet, i_cfg.universe[i]});
                end
            end else if (r_pos == POS_W'(POS_NET)) begin
                n_net = (r_byte == {1'b0, i_cfg.net});
            end else if (r_pos == POS_W'(POS_LENGTH_HI)) begin
                n_len[15:8] = r_byte;
            end else if (r_pos == POS_W'(POS_LENGTH_LO)) begin
                n_len[7:0] = r_byte;
            end else if (r_pos >= POS_W'(DATA_START)) begin
                slot_hit = r_hdr && (r_op == OP_DMX) && r_net && (r_mask != 4'd0)
                           && (16'(slot_k) < r_len) && (16'(slot_k) < 16'(MAX_SLOTS));
            end
            n_pos = r_pos + 1'b1;
        end

        if (!n_hdr) begin
            cls = CLS_NOT_ARTNET;
        end else if (n_pos < POS_W'(MIN_PACKET_BYTES)) begin
            cls = CLS_SHORT;
        end else if (n_op == OP_DMX) begin
            cls = (n_pos < POS_W'(DATA_START)) ? CLS_SHORT : CLS_DMX;
        end else if (n_op == OP_POLL) begin
            cls = CLS_POLL;
        end else if (n_op == OP_POLL_REPLY) begin
            cls = CLS_POLL_REPLY;
        end else begin
            cls = CLS_UNKNOWN;
        end

        slot_res.kind             = KIND_SLOT;
        slot_res.slot_index       = 9'(slot_k);
        slot_res.slot_value       = r_byte;
        slot_res.target_mask      = r_mask;
        slot_res.packet_class     = CLS_DMX;
        slot_res.announced_length = r_len;
        slot_res.last             = !r_eop;

        sum_res.kind              = KIND_SUMMARY;
        sum_res.slot_index        = 9'd0;
        sum_res.slot_value        = 8'd0;
        sum_res.target_mask       = (cls == CLS_DMX && n_net) ? n_mask : 4'd0;
        sum_res.packet_class      = cls;
        sum_res.announced_length  = (cls == CLS_DMX) ? n_len : 16'd0;
        sum_res.last              = 1'b1;

        o_push.count    = fire ? ({1'b0, slot_hit} + {1'b0, r_eop}) : 2'd0;
        o_push.entry[0] = slot_hit ? slot_res : sum_res;
        o_push.entry[1] = sum_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_payload_byte;
            r_eop  <= i_end_of_packet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_eop)) begin
            r_pos  <= '0;
            r_hdr  <= 1'b1;
            r_op   <= 16'd0;
            r_net  <= 1'b0;
            r_mask <= 4'd0;
            r_len  <= 16'd0;
        end else if (fire) begin
            r_pos  <= n_pos;
            r_hdr  <= n_hdr;
            r_op   <= n_op;
            r_net  <= n_net;
            r_mask <= n_mask;
            r_len  <= n_len;
        end
    end

    // A pair of results is always a slot followed by the packet summary.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |->
        (o_push.entry[1].kind == KIND_SUMMARY && !o_push.entry[0].last))
        else $error("result pair is not a slot followed by a summary");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_eop) |=> (r_pos == '0 && r_hdr && r_len == 16'd0))
        else $error("packet state not cleared after the end item");

    a_no_push_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> (o_push.count == 2'd0))
        else $error("result pushed without a held item");

endmodule

// File: rtl/artdmx_out_fifo.sv
// Four-entry result queue between the parser and the output channel.
// Depends on artdmx_pkg; accepts up to two results per cycle, delivers one per unstalled cycle.
`timescale 1ns / 1ps

module artdmx_out_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  artdmx_pkg::t_push    i_push,
    output logic                 o_room,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output artdmx_pkg::t_result  o_result
);
    import artdmx_pkg::*;

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [FIFO_CNT_W-1:0]  r_count;
    logic                   pop;

    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_room      = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign o_result    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.entry[0];
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + 1'b1] <= i_push.entry[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(i_push.count);
            r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(pop);
            r_count  <= r_count + FIFO_CNT_W'(i_push.count) - FIFO_CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_with_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("results pushed while the queue lacks room for a pair");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_result)))
        else $error("stalled result item changed or was dropped");

endmodule

// File: verif/tb.sv
// Self-checking testbench for the ArtDmx packet router: random Art-Net payloads with a
// scoreboard that predicts every slot and summary item. Depends on artdmx_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import artdmx_pkg::*;

    localparam int PACKET_BYTES = PACKET_BYTES_DEF;
    localparam int ITEMS = 1250;
    localparam int IDLE_LIMIT = 3000;
    localparam logic [63:0] ART_NET_ID = {"Art-Net", 8'h00};

    class router_scoreboard;
        logic [6:0]  net_addr;
        logic [3:0]  subnet_addr;
        logic [3:0]  universe [4];
        int unsigned position;
        bit          ident_ok;
        logic [15:0] opcode;
        bit          net_hit;
        logic [3:0]  universe_hits;
        logic [15:0] dmx_length;
        t_result     pending_results [$];
        int unsigned bytes_parsed;
        int unsigned mismatches;

        function new();
            net_addr = '0;
            subnet_addr = '0;
            universe = '{4'd1, 4'd2, 4'd3, 4'd4};
            bytes_parsed = 0;
            mismatches = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            position = 0;
            ident_ok = 1'b1;
            opcode = '0;
            net_hit = 1'b0;
            universe_hits = '0;
            dmx_length = '0;
        endfunction

        function void set_register(t_reg_index idx, logic [6:0] value);
            case (idx)
                REG_NET:        net_addr = value;
                REG_SUBNET:     subnet_addr = value[3:0];
                REG_UNIVERSE_A: universe[0] = value[3:0];
                REG_UNIVERSE_B: universe[1] = value[3:0];
                REG_UNIVERSE_C: universe[2] = value[3:0];
                REG_UNIVERSE_D: universe[3] = value[3:0];
                default: ;
            endcase
        endfunction

        function void predict_byte(logic [7:0] b, logic eop);
            t_result     produced [$];
            t_result     r;
            t_class      cls;
            int unsigned k;
            if (position < PACKET_BYTES) begin
                bytes_parsed++;
                if (position < IDENT_BYTES) begin
                    if (b != ART_NET_ID[63 - 8 * position -: 8]) ident_ok = 1'b0;
                end else if (position == POS_OPCODE_LO) begin
                    opcode[7:0] = b;
                end else if (position == POS_OPCODE_HI) begin
                    opcode[15:8] = b;
                end else if (position == POS_UNIVERSE) begin
                    universe_hits = '0;
                    for (int i = 0; i < NUM_OUTPUTS; i++) begin
                        if (b == {subnet_addr, universe[i]}) universe_hits[i] = 1'b1;
                    end
                end else if (position == POS_NET) begin
                    net_hit = (b == {1'b0, net_addr});
                end else if (position == POS_LENGTH_HI) begin
                    dmx_length[15:8] = b;
                end else if (position == POS_LENGTH_LO) begin
                    dmx_length[7:0] = b;
                end else if (position >= DATA_START) begin
                    k = position - DATA_START;
                    if (ident_ok && opcode == OP_DMX && net_hit && universe_hits != 0 &&
                        k < dmx_length && k < MAX_SLOTS) begin
                        r = '0;
                        r.kind = KIND_SLOT;
                        r.slot_index = k[8:0];
                        r.slot_value = b;
                        r.target_mask = universe_hits;
                        r.packet_class = CLS_DMX;
                        r.announced_length = dmx_length;
                        produced.push_back(r);
                    end
                end
                position++;
            end
            if (eop) begin
                r = '0;
                r.kind = KIND_SUMMARY;
                if (!ident_ok) cls = CLS_NOT_ARTNET;
                else if (position < MIN_PACKET_BYTES) cls = CLS_SHORT;
                else if (opcode == OP_DMX) cls = (position < DATA_START) ? CLS_SHORT : CLS_DMX;
                else if (opcode == OP_POLL) cls = CLS_POLL;
                else if (opcode == OP_POLL_REPLY) cls = CLS_POLL_REPLY;
                else cls = CLS_UNKNOWN;
                r.packet_class = cls;
                if (cls == CLS_DMX) begin
                    r.announced_length = dmx_length;
                    if (net_hit) r.target_mask = universe_hits;
                end
                produced.push_back(r);
                clear_packet();
            end
            if (produced.size() > 0) produced[produced.size() - 1].last = 1'b1;
            foreach (produced[i]) pending_results.push_back(produced[i]);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("unexpected item: kind %0d, slot %0d, class %0d",
                       got.kind, got.slot_index, got.packet_class);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("result_kind", want.kind, got.kind);
            compare_field("slot_index", want.slot_index, got.slot_index);
            compare_field("slot_value", want.slot_value, got.slot_value);
            compare_field("target_mask", want.target_mask, got.target_mask);
            compare_field("packet_class", want.packet_class, got.packet_class);
            compare_field("announced_length", want.announced_length, got.announced_length);
            compare_field("last_result", want.last, got.last);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [7:0]             payload_byte = '0;
    logic                   end_of_packet = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   result_kind;
    logic [8:0]             slot_index;
    logic [7:0]             slot_value;
    logic [3:0]             target_mask;
    logic [2:0]             packet_class;
    logic [15:0]            announced_length;
    logic                   last_result;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    router_scoreboard sb = new();
    logic [7:0] pkt [$];
    int burst_left = 0;
    int results_seen = 0;
    int idle_cycles = 0;

    artdmx_packet_router #(.PACKET_BYTES(PACKET_BYTES)) i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_payload_byte     (payload_byte),
        .i_end_of_packet    (end_of_packet),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_result_kind      (result_kind),
        .o_slot_index       (slot_index),
        .o_slot_value       (slot_value),
        .o_target_mask      (target_mask),
        .o_packet_class     (packet_class),
        .o_announced_length (announced_length),
        .o_last_result      (last_result),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(t_result'({result_kind, slot_index, slot_value, target_mask,
                                       packet_class, announced_length, last_result}));
            results_seen++;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // The receiver changes its stall pattern now and then, and twice holds off for a long
    // stretch so that the result queue fills and the input side has to stall.
    initial begin : result_sink
        int mode = 0;
        int span = 0;
        int hold_left = 0;
        int holds_done = 0;
        forever begin
            @(posedge clk);
            if (hold_left == 0 && holds_done < 2 && results_seen >= 250 + 250 * holds_done) begin
                hold_left = 300;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 300);
                end
                span--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= 1'($urandom_range(0, 1));
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ((span % 8) < 3);
                endcase
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic eop);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        in_valid <= 1'b1;
        payload_byte <= b;
        end_of_packet <= eop;
        do @(posedge clk); while (in_stall);
        sb.predict_byte(b, eop);
        burst_left--;
    endtask

    task automatic send_packet();
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
        pkt.delete();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(t_reg_index idx, logic [6:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        sb.set_register(idx, value);
    endtask

    task automatic apply_settings(logic [6:0] net_val, logic [3:0] subnet_val,
                                  logic [3:0] ua, logic [3:0] ub, logic [3:0] uc,
                                  logic [3:0] ud);
        write_reg(REG_NET, net_val);
        write_reg(REG_SUBNET, {3'b000, subnet_val});
        write_reg(REG_UNIVERSE_A, {3'b000, ua});
        write_reg(REG_UNIVERSE_B, {3'b000, ub});
        write_reg(REG_UNIVERSE_C, {3'b000, uc});
        write_reg(REG_UNIVERSE_D, {3'b000, ud});
        cfg_we <= 1'b0;
    endtask

    function automatic void push_header(logic [15:0] op);
        for (int i = 0; i < IDENT_BYTES; i++) pkt.push_back(ART_NET_ID[63 - 8 * i -: 8]);
        pkt.push_back(op[7:0]);
        pkt.push_back(op[15:8]);
    endfunction

    function automatic void push_random(int count);
        repeat (count) pkt.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void push_dmx(logic [7:0] uni_byte, logic [7:0] net_byte,
                                     logic [15:0] len, int n_data);
        push_header(OP_DMX);
        push_random(4);
        pkt.push_back(uni_byte);
        pkt.push_back(net_byte);
        pkt.push_back(len[15:8]);
        pkt.push_back(len[7:0]);
        push_random(n_data);
    endfunction

    function automatic logic [7:0] matched_universe();
        return {sb.subnet_addr, sb.universe[$urandom_range(0, 3)]};
    endfunction

    // Mostly well-formed ArtDmx packets for the current addresses; the rest are other
    // opcodes, corrupted identifiers, truncated headers and plain noise.
    task automatic random_packet();
        int          sel;
        int          n;
        int          cut;
        logic [15:0] len;
        logic [7:0]  uni_byte;
        logic [7:0]  net_byte;
        sel = $urandom_range(0, 99);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: len = 16'(n);
            4, 5:       len = 16'($urandom_range(0, n));
            6, 7:       len = 16'(n + $urandom_range(1, 8));
            8:          len = 16'd0;
            default:    len = 16'($urandom_range(0, 65535));
        endcase
        if (sel < 55) begin
            push_dmx(matched_universe(), {1'b0, sb.net_addr}, len, n);
        end else if (sel < 63) begin
            uni_byte = $urandom_range(0, 1) ? matched_universe() : 8'($urandom_range(0, 255));
            net_byte = $urandom_range(0, 1) ? {1'b0, sb.net_addr} : 8'($urandom_range(0, 255));
            push_dmx(uni_byte, net_byte, len, n);
        end else if (sel < 69) begin
            push_header(OP_POLL);
            push_random($urandom_range(0, 8));
        end else if (sel < 75) begin
            push_header(OP_POLL_REPLY);
            push_random($urandom_range(0, 40));
        end else if (sel < 81) begin
            push_header(16'($urandom_range(0, 65535)));
            push_random($urandom_range(0, 20));
        end else if (sel < 89) begin
            push_dmx(matched_universe(), {1'b0, sb.net_addr}, len, n);
            cut = $urandom_range(0, IDENT_BYTES - 1);
            pkt[cut] = pkt[cut] ^ (8'h01 << $urandom_range(0, 7));
        end else if (sel < 95) begin
            push_dmx(matched_universe(), {1'b0, sb.net_addr}, len, n);
            cut = $urandom_range(1, DATA_START - 1);
            while (pkt.size() > cut) void'(pkt.pop_back());
        end else begin
            push_random($urandom_range(1, 30));
        end
    endtask

    initial begin : stimulus
        int unsigned target;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset addresses: a one-byte short packet, a one-byte foreign packet, then an
        // ArtDmx packet whose end byte also carries a slot.
        pkt.push_back(8'h41);
        send_packet();
        pkt.push_back(8'hFF);
        send_packet();
        push_dmx(8'h01, 8'h00, 16'd2, 2);
        pkt[DATA_START] = 8'h00;
        pkt[DATA_START + 1] = 8'hFF;
        send_packet();
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: apply_settings(7'd0, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4);
                1: apply_settings(7'd127, 4'd15, 4'd15, 4'd0, 4'd15, 4'd7);
                2: apply_settings(7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)),
                                  4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                  4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
                3: apply_settings(7'd0, 4'd15, 4'd0, 4'd0, 4'd0, 4'd0);
                4: apply_settings(7'd127, 4'd0, 4'd0, 4'd15, 4'd15, 4'd15);
                default: apply_settings(7'($urandom_range(0, 127)),
                                        4'($urandom_range(0, 15)),
                                        4'($urandom_range(0, 15)),
                                        4'($urandom_range(0, 15)),
                                        4'($urandom_range(0, 15)),
                                        4'($urandom_range(0, 15)));
            endcase
            if (phase == 3) begin
                // One full-size packet: every slot up to the limit, then bytes past the end.
                push_dmx(matched_universe(), {1'b0, sb.net_addr}, 16'hFFFF,
                         PACKET_BYTES - DATA_START + $urandom_range(1, 12));
                send_packet();
            end
            target = sb.bytes_parsed + (ITEMS - PACKET_BYTES) / 6;
            while (sb.bytes_parsed < target) begin
                random_packet();
                send_packet();
            end
            wait_drained();
        end

        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/artdmx_pkg.sv
rtl/artdmx_cfg.sv
rtl/artdmx_parser.sv
rtl/artdmx_out_fifo.sv
rtl/artdmx_packet_router.sv
verif/tb.sv
